FILE: sv/qse_pkg.sv
// Package for the queens sub-board enumerator.
// Holds the constants, register indexes, stack frame and controller state type.
// No dependencies.
`default_nettype none

package qse_pkg;

    localparam int unsigned STACK_DEPTH_DEFAULT = 32;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic signed [7:0] LOOK_ROWS = 8'sd3;

    localparam logic [4:0] BOARD_SIZE_RESET   = 5'd16;
    localparam logic [4:0] PLACED_COUNT_RESET = 5'd2;
    localparam logic [5:0] SEARCH_DEPTH_RESET = 6'd1;

    typedef enum logic [1:0] {
        REG_BOARD_SIZE   = 2'd0,
        REG_PLACED_COUNT = 2'd1,
        REG_SEARCH_DEPTH = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef struct packed {
        logic [31:0]        cols;
        logic [31:0]        left_diag;
        logic [31:0]        right_diag;
        logic [31:0]        options;
        logic signed [7:0]  remaining;
    } frame_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_POP,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: sv/queens_subboard_enumerator_top.sv
// Flow: a load goes from S_IDLE to S_EMIT and its result is registered on the output; a fetch
// on an active search of nonzero depth tries one candidate bit per S_SEARCH step, and each
// backtrack to an earlier row passes through S_POP. One item at a time: s_ready is high only
// in S_IDLE, so a new command is taken only after the last result has left S_EMIT.
// Reset: aresetn is synchronous and active low; the search becomes inactive, config registers
// take their defaults. The frame stack has no reset and is always written before it is read.
`default_nettype none

module queens_subboard_enumerator_top #(
    parameter int unsigned STACK_DEPTH = qse_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [31:0] s_start_cols,
    input  wire logic [31:0] s_start_left_diag,
    input  wire logic [31:0] s_start_right_diag,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic      [31:0] m_sub_cols,
    output logic      [31:0] m_sub_left_diag,
    output logic      [31:0] m_sub_right_diag,
    output logic             m_exhausted
);

    localparam int unsigned LVL_W = $clog2(STACK_DEPTH);
    localparam logic [LVL_W:0] DEPTH_L = (LVL_W+1)'(STACK_DEPTH);

    // Configuration registers.
    logic [4:0] board_size_reg;
    logic [4:0] placed_count_reg;
    logic [5:0] search_depth_reg;
    qse_pkg::reg_index_t cfg_index;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = qse_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_size_reg   <= qse_pkg::BOARD_SIZE_RESET;
            placed_count_reg <= qse_pkg::PLACED_COUNT_RESET;
            search_depth_reg <= qse_pkg::SEARCH_DEPTH_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                qse_pkg::REG_BOARD_SIZE:   board_size_reg   <= pwdata[4:0];
                qse_pkg::REG_PLACED_COUNT: placed_count_reg <= pwdata[4:0];
                qse_pkg::REG_SEARCH_DEPTH: search_depth_reg <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            qse_pkg::REG_BOARD_SIZE:   prdata = {27'd0, board_size_reg};
            qse_pkg::REG_PLACED_COUNT: prdata = {27'd0, placed_count_reg};
            qse_pkg::REG_SEARCH_DEPTH: prdata = {26'd0, search_depth_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Search state.
    qse_pkg::state_t state_reg, state_next;
    logic              active_reg, active_next;
    logic              zero_depth_reg, zero_depth_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [31:0]       opt_reg, opt_next;
    logic [31:0]       col_reg, col_next;
    logic [31:0]       ld_reg, ld_next;
    logic [31:0]       rd_reg, rd_next;
    logic signed [7:0] rem_reg, rem_next;
    logic signed [7:0] target_reg, target_next;
    logic [31:0]       held_cols_reg, held_cols_next;
    logic [31:0]       held_left_reg, held_left_next;
    logic [31:0]       held_right_reg, held_right_next;
    logic              res_found_reg, res_found_next;
    logic [31:0]       res_cols_reg, res_cols_next;
    logic [31:0]       res_left_reg, res_left_next;
    logic [31:0]       res_right_reg, res_right_next;
    logic              res_exh_reg, res_exh_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg;
    logic [31:0]       m_cols_reg, m_left_reg, m_right_reg;
    logic              m_exh_reg;

    // Frame stack.
    qse_pkg::frame_t   stack_mem [STACK_DEPTH];
    qse_pkg::frame_t   wr_frame, rd_frame_reg;
    logic              wr_en, rd_en;
    logic [LVL_W-1:0]  wr_addr, rd_addr;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_frame;
        end
        if (rd_en) begin
            rd_frame_reg <= stack_mem[rd_addr];
        end
    end

    logic s_accept, out_free;
    assign s_ready  = (state_reg == qse_pkg::S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Candidate unit: lowest free bit and the look-ahead checks.
    logic [31:0]       bit_w, opt_x, nl_w, nr_w, bc_w, np_w, la1_w, la2_w;
    logic              prune_w, exhausted_row;
    logic [LVL_W:0]    nd_w;
    assign exhausted_row = (opt_reg == qse_pkg::ALL_ONES);
    assign bit_w   = ~opt_reg & (opt_reg + 32'd1);
    assign opt_x   = opt_reg ^ bit_w;
    assign nl_w    = (bit_w << 1) | ld_reg;
    assign nr_w    = (bit_w >> 1) | rd_reg;
    assign bc_w    = bit_w | col_reg;
    assign np_w    = bc_w | nl_w | nr_w;
    assign la1_w   = bc_w | (nl_w << 1) | (nr_w >> 1);
    assign la2_w   = bc_w | (nl_w << 2) | (nr_w >> 2);
    assign prune_w = (rem_reg > 8'sd0)
                     && (la1_w == qse_pkg::ALL_ONES || la2_w == qse_pkg::ALL_ONES);
    assign nd_w    = {1'b0, level_reg} + {{LVL_W{1'b0}}, (opt_x != qse_pkg::ALL_ONES)};

    // Load arithmetic.
    logic [31:0]       load_cols, load_opt;
    logic signed [7:0] load_rest;
    logic              load_ok;
    assign load_cols = s_start_cols | (qse_pkg::ALL_ONES << board_size_reg);
    assign load_opt  = load_cols | s_start_left_diag | s_start_right_diag;
    assign load_rest = $signed({3'd0, board_size_reg}) - qse_pkg::LOOK_ROWS
                       - $signed({3'd0, placed_count_reg});
    assign load_ok   = (board_size_reg >= 5'd2) && (placed_count_reg != 5'd0)
                       && (32'(search_depth_reg) <= STACK_DEPTH);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            qse_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (s_cmd == qse_pkg::CMD_FETCH && active_reg && !zero_depth_reg) begin
                        state_next = qse_pkg::S_SEARCH;
                    end else begin
                        state_next = qse_pkg::S_EMIT;
                    end
                end
            end
            qse_pkg::S_SEARCH: begin
                if (exhausted_row) begin
                    state_next = (level_reg <= LVL_W'(1)) ? qse_pkg::S_EMIT : qse_pkg::S_POP;
                end else if (np_w != qse_pkg::ALL_ONES && !prune_w && rem_reg == target_reg) begin
                    state_next = qse_pkg::S_EMIT;
                end
            end
            qse_pkg::S_POP:  state_next = qse_pkg::S_SEARCH;
            qse_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = qse_pkg::S_IDLE;
                end
            end
            default: state_next = qse_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        active_next     = active_reg;
        zero_depth_next = zero_depth_reg;
        level_next      = level_reg;
        opt_next        = opt_reg;
        col_next        = col_reg;
        ld_next         = ld_reg;
        rd_next         = rd_reg;
        rem_next        = rem_reg;
        target_next     = target_reg;
        held_cols_next  = held_cols_reg;
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        res_found_next  = res_found_reg;
        res_cols_next   = res_cols_reg;
        res_left_next   = res_left_reg;
        res_right_next  = res_right_reg;
        res_exh_next    = res_exh_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        wr_en           = 1'b0;
        wr_addr         = level_reg;
        wr_frame        = '{cols: col_reg, left_diag: ld_reg, right_diag: rd_reg,
                            options: opt_x, remaining: rem_reg};
        rd_en           = 1'b0;
        rd_addr         = level_reg - LVL_W'(1);
        unique case (state_reg)
            qse_pkg::S_IDLE: begin
                if (s_accept) begin
                    res_found_next = 1'b0;
                    res_cols_next  = 32'd0;
                    res_left_next  = 32'd0;
                    res_right_next = 32'd0;
                    if (s_cmd == qse_pkg::CMD_LOAD) begin
                        held_cols_next  = s_start_cols;
                        held_left_next  = s_start_left_diag;
                        held_right_next = s_start_right_diag;
                        zero_depth_next = (search_depth_reg == 6'd0);
                        level_next      = LVL_W'(1);
                        opt_next        = qse_pkg::ALL_ONES;
                        active_next     = 1'b0;
                        res_exh_next    = 1'b1;
                        if (load_ok) begin
                            col_next     = load_cols;
                            rem_next     = load_rest;
                            target_next  = load_rest - $signed({2'd0, search_depth_reg})
                                           + 8'sd1;
                            opt_next     = load_opt;
                            ld_next      = s_start_left_diag << 1;
                            rd_next      = s_start_right_diag >> 1;
                            active_next  = (load_opt != qse_pkg::ALL_ONES);
                            res_exh_next = (load_opt == qse_pkg::ALL_ONES);
                        end
                    end else if (!active_reg) begin
                        res_exh_next = 1'b1;
                    end else if (zero_depth_reg) begin
                        active_next    = 1'b0;
                        res_found_next = 1'b1;
                        res_cols_next  = held_cols_reg;
                        res_left_next  = held_left_reg;
                        res_right_next = held_right_reg;
                        res_exh_next   = 1'b1;
                    end
                end
            end
            qse_pkg::S_SEARCH: begin
                if (exhausted_row) begin
                    level_next = level_reg - LVL_W'(1);
                    if (level_reg <= LVL_W'(1)) begin
                        level_next     = '0;
                        opt_next       = qse_pkg::ALL_ONES;
                        active_next    = 1'b0;
                        res_found_next = 1'b0;
                        res_cols_next  = 32'd0;
                        res_left_next  = 32'd0;
                        res_right_next = 32'd0;
                        res_exh_next   = 1'b1;
                    end else begin
                        rd_en = 1'b1;
                    end
                end else begin
                    opt_next = opt_x;
                    if (np_w != qse_pkg::ALL_ONES && !prune_w) begin
                        if (rem_reg == target_reg) begin
                            res_found_next = 1'b1;
                            res_cols_next  = bc_w;
                            res_left_next  = nl_w;
                            res_right_next = nr_w;
                            res_exh_next   = 1'b0;
                        end else if (nd_w < DEPTH_L) begin
                            wr_en      = (opt_x != qse_pkg::ALL_ONES);
                            level_next = nd_w[LVL_W-1:0];
                            opt_next   = np_w;
                            col_next   = bc_w;
                            ld_next    = nl_w << 1;
                            rd_next    = nr_w >> 1;
                            rem_next   = rem_reg - 8'sd1;
                        end
                    end
                end
            end
            qse_pkg::S_POP: begin
                col_next = rd_frame_reg.cols;
                ld_next  = rd_frame_reg.left_diag;
                rd_next  = rd_frame_reg.right_diag;
                opt_next = rd_frame_reg.options;
                rem_next = rd_frame_reg.remaining;
            end
            qse_pkg::S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= qse_pkg::S_IDLE;
            active_reg     <= 1'b0;
            zero_depth_reg <= 1'b0;
            level_reg      <= '0;
            opt_reg        <= qse_pkg::ALL_ONES;
            target_reg     <= 8'sd0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            zero_depth_reg <= zero_depth_next;
            level_reg      <= level_next;
            opt_reg        <= opt_next;
            target_reg     <= target_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg        <= col_next;
        ld_reg         <= ld_next;
        rd_reg         <= rd_next;
        rem_reg        <= rem_next;
        held_cols_reg  <= held_cols_next;
        held_left_reg  <= held_left_next;
        held_right_reg <= held_right_next;
        res_found_reg  <= res_found_next;
        res_cols_reg   <= res_cols_next;
        res_left_reg   <= res_left_next;
        res_right_reg  <= res_right_next;
        res_exh_reg    <= res_exh_next;
        if (state_reg == qse_pkg::S_EMIT && out_free) begin
            m_found_reg <= res_found_reg;
            m_cols_reg  <= res_cols_reg;
            m_left_reg  <= res_left_reg;
            m_right_reg <= res_right_reg;
            m_exh_reg   <= res_exh_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_found          = m_found_reg;
    assign m_sub_cols       = m_cols_reg;
    assign m_sub_left_diag  = m_left_reg;
    assign m_sub_right_diag = m_right_reg;
    assign m_exhausted      = m_exh_reg;

`ifndef SYNTHESIS
    a_search_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == qse_pkg::S_SEARCH) |-> active_reg)
        else $error("Search running while inactive.");
    a_pop_resumes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == qse_pkg::S_POP) |=> (state_reg == qse_pkg::S_SEARCH))
        else $error("Backtrack did not resume the search.");
    a_pop_from_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == qse_pkg::S_POP) |-> ($past(state_reg) == qse_pkg::S_SEARCH && level_reg != '0))
        else $error("Backtrack entered from the wrong state.");
    a_no_push_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("Stack written and read in the same cycle.");
`endif

endmodule

`default_nettype wire
